/* hdl/pogac_pkg.sv */
// Shared types, codes and constants for the point occupancy grid accumulator.
// Used by every module under hdl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pogac_pkg;

  // Default grid shape
  localparam int GRID_ROWS_DEF = 140;
  localparam int GRID_COLS_DEF = 70;

  // Index width inside the datapath, sized for the largest grid (1024)
  localparam int IDX_W      = 10;
  localparam int CELL_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int FRAC_W     = 20;
  localparam int PROD_W     = 39;
  localparam int Q_DEPTH    = 2;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAND = 2'd1,
    ST_NEG  = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_INV_CELL   = 3'd2,
    CFG_HEIGHT_MIN = 3'd3,
    CFG_HEIGHT_MAX = 3'd4,
    CFG_HIT_STEP   = 3'd5,
    CFG_HIT_LIMIT  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic signed [15:0] z_mm;
    logic [7:0]         read_row;
    logic [6:0]         read_col;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        cell_row;
    logic [6:0]        cell_col;
    logic [CELL_W-1:0] cell_value;
  } out_t;

  typedef struct packed {
    logic signed [15:0] origin_x_mm;
    logic signed [15:0] origin_y_mm;
    logic [20:0]        inv_cell_q20;
    logic signed [15:0] height_min_mm;
    logic signed [15:0] height_max_mm;
    logic [4:0]         hit_step;
    logic [CELL_W-1:0]  hit_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    origin_x_mm:   16'sd0,
    origin_y_mm:   -16'sd7000,
    inv_cell_q20:  21'd10486,
    height_min_mm: 16'sd200,
    height_max_mm: 16'sd2000,
    hit_step:      5'd10,
    hit_limit:     7'd100
  };

  // Classified job handed from front end to back end
  typedef struct packed {
    opcode_t          op;
    status_t          status;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } job_t;

  typedef struct packed {
    logic clearing;
    logic active;
  } back_stat_t;

endpackage

`default_nettype wire

/* hdl/pogac_front.sv */
// Front end: height band test, offset, Q20 binning, clamp and classification.
// Depends on pogac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pogac_front #(
  parameter int GRID_ROWS = pogac_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = pogac_pkg::GRID_COLS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire pogac_pkg::in_t   item,
  input  wire pogac_pkg::cfg_t  cfg,
  output logic                  push,
  output pogac_pkg::job_t       job,
  output logic                  busy
);

  localparam int PW   = pogac_pkg::PROD_W;
  localparam int FW   = pogac_pkg::FRAC_W;
  localparam int IW   = pogac_pkg::IDX_W;
  localparam int PIDX = PW - 1 - FW;

  // stage 1: offsets and band test
  logic                     s1_v_r, s1_v_nxt;
  pogac_pkg::opcode_t       s1_op_r;
  logic signed [16:0]       s1_dx_r, s1_dy_r;
  logic                     s1_band_r;
  logic [7:0]               s1_rrow_r;
  logic [6:0]               s1_rcol_r;

  // stage 2: products
  logic                     s2_v_r, s2_v_nxt;
  pogac_pkg::opcode_t       s2_op_r;
  logic signed [PW-1:0]     s2_px_r, s2_py_r;
  logic                     s2_band_r;
  logic [7:0]               s2_rrow_r;
  logic [6:0]               s2_rcol_r;

  logic signed [PW-1:0]     inv_s;
  logic                     neg_x, neg_y;
  logic [PIDX-1:0]          pcol, prow;
  logic [IW-1:0]            rrow_w, rcol_w;

  assign s1_v_nxt = accept;
  assign s2_v_nxt = s1_v_r;
  assign inv_s    = PW'($signed({1'b0, cfg.inv_cell_q20}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= item.opcode;
      s1_dx_r   <= 17'(item.x_mm) - 17'(cfg.origin_x_mm);
      s1_dy_r   <= 17'(item.y_mm) - 17'(cfg.origin_y_mm);
      s1_band_r <= (item.z_mm >= cfg.height_min_mm) && (item.z_mm <= cfg.height_max_mm);
      s1_rrow_r <= item.read_row;
      s1_rcol_r <= item.read_col;
    end
    if (s1_v_r) begin
      s2_op_r   <= s1_op_r;
      s2_px_r   <= PW'(s1_dx_r) * inv_s;
      s2_py_r   <= PW'(s1_dy_r) * inv_s;
      s2_band_r <= s1_band_r;
      s2_rrow_r <= s1_rrow_r;
      s2_rcol_r <= s1_rcol_r;
    end
  end

  // Truncation toward zero: products in (-2^20, 0) land on index 0,
  // anything at or below -2^20 is a negative index.
  assign neg_x = s2_px_r[PW-1] && !((&s2_px_r[PW-1:FW]) && (|s2_px_r[FW-1:0]));
  assign neg_y = s2_py_r[PW-1] && !((&s2_py_r[PW-1:FW]) && (|s2_py_r[FW-1:0]));
  assign pcol  = s2_px_r[PW-1] ? '0 : s2_px_r[PW-2:FW];
  assign prow  = s2_py_r[PW-1] ? '0 : s2_py_r[PW-2:FW];
  assign rrow_w = IW'(s2_rrow_r);
  assign rcol_w = IW'(s2_rcol_r);

  always_comb begin
    job        = '0;
    job.op     = s2_op_r;
    job.status = pogac_pkg::ST_OK;
    if (s2_op_r == pogac_pkg::OP_READ) begin
      job.row = (rrow_w > IW'(GRID_ROWS - 1)) ? IW'(GRID_ROWS - 1) : rrow_w;
      job.col = (rcol_w > IW'(GRID_COLS - 1)) ? IW'(GRID_COLS - 1) : rcol_w;
    end else if (!s2_band_r) begin
      job.status = pogac_pkg::ST_BAND;
    end else if (neg_x || neg_y) begin
      job.status = pogac_pkg::ST_NEG;
    end else begin
      job.row = (prow > PIDX'(GRID_ROWS - 1)) ? IW'(GRID_ROWS - 1) : IW'(prow);
      job.col = (pcol > PIDX'(GRID_COLS - 1)) ? IW'(GRID_COLS - 1) : IW'(pcol);
    end
  end

  assign push = s2_v_r;
  assign busy = s1_v_r | s2_v_r;

endmodule

`default_nettype wire

/* hdl/pogac_fifo.sv */
// Short job queue between front end and back end.
// Depends on pogac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pogac_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pogac_pkg::job_t wdata,
  input  wire logic            pop,
  output pogac_pkg::job_t      head,
  output logic                 empty
);

  localparam int DEPTH = pogac_pkg::Q_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pogac_pkg::job_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign do_pop  = pop && !empty;
  assign do_push = push && (count_r != CNT_W'(DEPTH));
  assign head    = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* hdl/pogac_back.sv */
// Back end: grid memory with clearing pass, read-modify-write and result register.
// Depends on pogac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pogac_back #(
  parameter int GRID_ROWS = pogac_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = pogac_pkg::GRID_COLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire pogac_pkg::job_t   q_head,
  output logic                   q_pop,
  input  wire pogac_pkg::cfg_t   cfg,
  output logic                   out_valid,
  output pogac_pkg::out_t        out_result,
  output pogac_pkg::back_stat_t  stat
);

  localparam int DEPTH  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = pogac_pkg::CELL_W;

  logic [CW-1:0]         mem [DEPTH];
  logic [CW-1:0]         mem_q_r;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  logic [CW-1:0]         mem_wd;

  logic                  clr_active_r, clr_active_nxt;
  logic [ADDR_W-1:0]     clr_cnt_r, clr_cnt_nxt;

  logic                  b1_v_r, b1_v_nxt;
  pogac_pkg::job_t       b1_job_r;
  logic [ADDR_W-1:0]     b1_addr_r;
  logic                  b2_v_r, b2_v_nxt;
  pogac_pkg::job_t       b2_job_r;
  logic [ADDR_W-1:0]     b2_addr_r;

  logic                  out_valid_r;
  pogac_pkg::out_t       out_result_r, res_nxt;
  logic                  upd_we;
  logic [CW-1:0]         upd_wd;
  logic [CW:0]           sum;

  assign q_pop    = !q_empty && !clr_active_r;
  assign b1_v_nxt = q_pop;
  assign b2_v_nxt = b1_v_r;

  // Clearing pass over every cell after reset
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_cnt_nxt    = clr_cnt_r;
    if (clr_active_r) begin
      if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      b1_v_r       <= 1'b0;
      b2_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      b1_v_r       <= b1_v_nxt;
      b2_v_r       <= b2_v_nxt;
      out_valid_r  <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_job_r  <= q_head;
      b1_addr_r <= ADDR_W'(q_head.row * GRID_COLS + q_head.col);
    end
    if (b1_v_r) begin
      b2_job_r  <= b1_job_r;
      b2_addr_r <= b1_addr_r;
    end
    if (b2_v_r) begin
      out_result_r <= res_nxt;
    end
  end

  // Result and update of the cell read in the previous cycle; a read job writes the cell back to zero
  assign sum = {1'b0, mem_q_r} + (CW + 1)'(cfg.hit_step);

  always_comb begin
    res_nxt        = '0;
    res_nxt.status = b2_job_r.status;
    upd_we         = 1'b0;
    upd_wd         = '0;
    if (b2_job_r.op == pogac_pkg::OP_READ) begin
      res_nxt.cell_row   = b2_job_r.row[7:0];
      res_nxt.cell_col   = b2_job_r.col[6:0];
      res_nxt.cell_value = mem_q_r;
      upd_we             = b2_v_r;
    end else if (b2_job_r.status == pogac_pkg::ST_OK) begin
      res_nxt.cell_row = b2_job_r.row[7:0];
      res_nxt.cell_col = b2_job_r.col[6:0];
      if (mem_q_r < cfg.hit_limit) begin
        upd_wd             = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
        upd_we             = b2_v_r;
        res_nxt.cell_value = upd_wd;
      end else begin
        res_nxt.status     = pogac_pkg::ST_SAT;
        res_nxt.cell_value = mem_q_r;
      end
    end
  end

  assign mem_we = clr_active_r | upd_we;
  assign mem_wa = clr_active_r ? clr_cnt_r : b2_addr_r;
  assign mem_wd = clr_active_r ? '0 : upd_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[b1_addr_r];
  end

  assign out_valid     = out_valid_r;
  assign out_result    = out_result_r;
  assign stat.clearing = clr_active_r;
  assign stat.active   = b1_v_r | b2_v_r;

endmodule

`default_nettype wire

/* hdl/point_occupancy_grid_accumulator_top.sv */
// Top level of the point occupancy grid accumulator: configuration registers,
// front end, job queue and back end. Depends on pogac_pkg and all hdl modules.
`timescale 1ns / 1ps
`default_nettype none

// After reset the grid is swept to zero, one cell a cycle, over all GRID_ROWS*GRID_COLS
// cells (9800 at the default 140 x 70); busy stays high through the sweep.
// Each item is then taken by start while busy is low. Its result is on out_result with
// out_valid high for exactly one cycle, after the offset and product registers, the
// queue, the address and read registers and the result register. Busy falls as out_valid
// rises, so a new item is taken only once the last has reached the result register.
// The item spacing is set by the single-item path: two front-end stages (offset, then
// Q20 multiply), the queue, and the grid memory read-modify-write with its
// registered read port. Results cannot be held off: sample out_result whenever
// out_valid is high. Configuration writes take effect at once and belong to the
// idle time between items.
module point_occupancy_grid_accumulator_top #(
  parameter int GRID_ROWS = pogac_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = pogac_pkg::GRID_COLS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire pogac_pkg::in_t                   in_item,
  output logic                                  out_valid,
  output pogac_pkg::out_t                       out_result,
  input  wire logic                             cfg_we,
  input  wire logic [pogac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pogac_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pogac_pkg::cfg_t       cfg_r, cfg_nxt;
  logic                  accept;
  logic                  fe_push, fe_busy;
  pogac_pkg::job_t       fe_job, q_head;
  logic                  q_empty, q_pop;
  pogac_pkg::back_stat_t bk_stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pogac_pkg::CFG_ORIGIN_X:   cfg_nxt.origin_x_mm   = cfg_wdata[15:0];
        pogac_pkg::CFG_ORIGIN_Y:   cfg_nxt.origin_y_mm   = cfg_wdata[15:0];
        pogac_pkg::CFG_INV_CELL:   cfg_nxt.inv_cell_q20  = cfg_wdata[20:0];
        pogac_pkg::CFG_HEIGHT_MIN: cfg_nxt.height_min_mm = cfg_wdata[15:0];
        pogac_pkg::CFG_HEIGHT_MAX: cfg_nxt.height_max_mm = cfg_wdata[15:0];
        pogac_pkg::CFG_HIT_STEP:   cfg_nxt.hit_step      = cfg_wdata[4:0];
        pogac_pkg::CFG_HIT_LIMIT:  cfg_nxt.hit_limit     = cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pogac_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign accept = start && !busy;
  assign busy   = bk_stat.clearing | bk_stat.active | fe_busy | !q_empty;

  pogac_front #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .cfg    (cfg_r),
    .push   (fe_push),
    .job    (fe_job),
    .busy   (fe_busy)
  );

  pogac_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .wdata (fe_job),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  pogac_back #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .cfg        (cfg_r),
    .out_valid  (out_valid),
    .out_result (out_result),
    .stat       (bk_stat)
  );

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_valid)
    else $error("transfer accepted without result six cycles later");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 6))
    else $error("result strobe without a matching accepted transfer");

  a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result.status == pogac_pkg::ST_BAND ||
                  out_result.status == pogac_pkg::ST_NEG)
    |-> out_result.cell_row == '0 && out_result.cell_col == '0 &&
        out_result.cell_value == '0)
    else $error("dropped point reports a cell");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.clearing |-> busy && !out_valid)
    else $error("activity during clearing pass");
`endif

endmodule

`default_nettype wire
